### hw/rtl/sobc_pkg.sv
package sobc_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int DATA_W          = 40;
    localparam int COEF_FRAC_BITS  = 22;
    localparam int STATE_FRAC_BITS = 16;
    localparam int NUM_SEC         = 3;
    localparam int NUM_DELAY       = 2 * NUM_SEC;
    localparam int NUM_COEF        = 4 * NUM_SEC + 1;
    localparam int SEC_W           = $clog2(NUM_SEC);
    localparam int DELAY_IDX_W     = $clog2(NUM_DELAY);
    localparam int COEF_IDX_W      = $clog2(NUM_COEF);

    localparam longint unsigned DEC_ONE = 64'd100000000000000;

    // Decimal coefficients scaled by 1e14, in the order the sequencer uses them:
    // gain, then per section -a1, -a2, b1, b2 (feedback terms pre-negated so
    // every product is added).
    localparam longint DEC_COEF [NUM_COEF] = '{
        64'sd3414078953606,
        64'sd48033201782190,  -64'sd86634101582270,
        64'sd165032341780200,  64'sd99008849090250,
        64'sd57590495725740,  -64'sd55046261887410,
        64'sd51155516318380,   64'sd99959211052690,
        64'sd73393951834220,  -64'sd20871364581170,
        64'sd4767870489813,    64'sd99999866624370
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_SUM,
        ST_ACC,
        ST_SAT_W,
        ST_SAT_Y,
        ST_GAIN_CLR,
        ST_SAT_G,
        ST_OUT
    } sobc_state_t;

    typedef struct packed {
        logic mul_hi;
        logic mul_lo;
        logic sum;
        logic acc_add;
        logic acc_load;
        logic acc_clear;
        logic acc_resat;
    } sobc_mac_ctrl_t;

    typedef struct packed {
        logic                   in_ready;
        logic                   src_x;
        logic [DELAY_IDX_W-1:0] delay_idx;
        logic [COEF_IDX_W-1:0]  coef_idx;
        logic                   w_store;
        logic                   y_store;
        logic                   g_store;
        logic                   out_load;
    } sobc_dp_ctrl_t;

    // Decimal constant to fixed point with frac fraction bits, round half away
    // from zero. Elaboration time only.
    function automatic longint to_fixed(input longint dec, input int frac);
        longint unsigned m;
        longint unsigned q;
        longint unsigned r;
        int              i;
        m = (dec < 0) ? longint'(-dec) : longint'(dec);
        q = m / DEC_ONE;
        r = m % DEC_ONE;
        for (i = 0; i < frac; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= DEC_ONE)
            begin
                r = r - DEC_ONE;
                q = q | 64'd1;
            end
        end
        if (2 * r >= DEC_ONE)
        begin
            q = q + 64'd1;
        end
        return (dec < 0) ? -longint'(q) : longint'(q);
    endfunction

endpackage

### hw/rtl/sobc_in_if.sv
interface sobc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sobc_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

### hw/rtl/sobc_out_if.sv
interface sobc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sobc_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

### hw/rtl/sixth_order_iir_biquad_cascade.sv
// Sixth-order IIR filter: three direct-form-II biquads in cascade with a
// fixed gain after the first, coefficients fixed at elaboration (Q2.22 by
// default), 40-bit state with 16 fraction bits, output truncated toward
// zero and saturated to 16 bits. One sample is in flight at a time: feed
// is ready only while the block is idle, which it reaches again once the
// last result has gone into the output register. The single shared 21x24
// multiplier forms each of the 13 products in two halves, each product
// passing through the multiply-high, multiply-low, sum and accumulate
// states in turn. A finished result waits in the output register, so the
// next sample can be taken while it is still pending.
module sixth_order_iir_biquad_cascade #(
    parameter int COEF_FRAC_BITS = sobc_pkg::COEF_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    sobc_in_if.sink           feed,
    sobc_out_if.source        result
);

    localparam int DATA_W   = sobc_pkg::DATA_W;
    localparam int SAMPLE_W = sobc_pkg::SAMPLE_W;
    localparam int SF       = sobc_pkg::STATE_FRAC_BITS;
    localparam int COEF_W   = COEF_FRAC_BITS + 2;
    localparam int Q_W      = DATA_W - SF;

    sobc_pkg::sobc_mac_ctrl_t  mac_ctrl;
    sobc_pkg::sobc_dp_ctrl_t   dp_ctrl;

    logic signed [COEF_W-1:0]   coef_tab [sobc_pkg::NUM_COEF];
    logic signed [DATA_W-1:0]   delay_reg [sobc_pkg::NUM_DELAY];
    logic signed [DATA_W-1:0]   x_reg;
    logic signed [DATA_W-1:0]   w_reg;
    logic signed [DATA_W-1:0]   acc_sat;
    logic signed [DATA_W-1:0]   operand;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       out_valid_reg;
    logic                       out_free;
    logic                       in_xfer;
    logic [sobc_pkg::DELAY_IDX_W-1:0] d1_idx;
    logic [sobc_pkg::DELAY_IDX_W-1:0] d2_idx;
    logic signed [DATA_W-1:0]   x_shr;
    logic signed [Q_W-1:0]      q_trunc;
    logic [Q_W-SAMPLE_W:0]      q_top;
    logic signed [SAMPLE_W-1:0] q_sat;

    for (genvar i = 0; i < sobc_pkg::NUM_COEF; i++)
    begin : g_coef
        localparam longint FIX = sobc_pkg::to_fixed(sobc_pkg::DEC_COEF[i], COEF_FRAC_BITS);
        assign coef_tab[i] = FIX[COEF_W-1:0];
    end

    assign in_xfer      = feed.valid && feed.ready;
    assign feed.ready   = dp_ctrl.in_ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign result.valid = out_valid_reg;
    assign result.sample_out = sample_reg;

    assign d1_idx  = {dp_ctrl.delay_idx[sobc_pkg::DELAY_IDX_W-1:1], 1'b0};
    assign d2_idx  = {dp_ctrl.delay_idx[sobc_pkg::DELAY_IDX_W-1:1], 1'b1};
    assign operand = dp_ctrl.src_x ? x_reg : delay_reg[dp_ctrl.delay_idx];

    // Final value: truncate toward zero, then clamp to the sample range.
    assign x_shr   = x_reg >>> SF;
    assign q_trunc = x_shr[Q_W-1:0] + Q_W'(x_reg[DATA_W-1] && (|x_reg[SF-1:0]));
    assign q_top   = q_trunc[Q_W-1:SAMPLE_W-1];

    always_comb
    begin
        if ((&q_top) || !(|q_top))
        begin
            q_sat = q_trunc[SAMPLE_W-1:0];
        end
        else
        begin
            q_sat = q_trunc[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    sobc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (feed.valid),
        .out_free (out_free),
        .mac_ctrl (mac_ctrl),
        .dp_ctrl  (dp_ctrl)
    );

    sobc_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .operand  (operand),
        .coef     (coef_tab[dp_ctrl.coef_idx]),
        .load_val (x_reg),
        .acc_sat  (acc_sat)
    );

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg <= DATA_W'(feed.sample_in) <<< SF;
        end
        else if (dp_ctrl.y_store || dp_ctrl.g_store)
        begin
            x_reg <= acc_sat;
        end
        if (dp_ctrl.w_store)
        begin
            w_reg <= acc_sat;
        end
        if (dp_ctrl.out_load)
        begin
            sample_reg <= q_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sobc_pkg::NUM_DELAY; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else if (dp_ctrl.y_store)
        begin
            delay_reg[d2_idx] <= delay_reg[d1_idx];
            delay_reg[d1_idx] <= w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctrl.out_load |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten while pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !feed.ready)
        else $error("feed still ready after a transfer");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(dp_ctrl.out_load))
        else $error("result valid without an output load");

endmodule

### hw/rtl/sobc_mac.sv
module sobc_mac #(
    parameter int COEF_FRAC_BITS = sobc_pkg::COEF_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sobc_pkg::sobc_mac_ctrl_t             ctrl,
    input  logic signed [sobc_pkg::DATA_W-1:0]   operand,
    input  logic signed [COEF_FRAC_BITS+1:0]     coef,
    input  logic signed [sobc_pkg::DATA_W-1:0]   load_val,
    output logic signed [sobc_pkg::DATA_W-1:0]   acc_sat
);

    localparam int DATA_W  = sobc_pkg::DATA_W;
    localparam int COEF_W  = COEF_FRAC_BITS + 2;
    localparam int HALF_W  = DATA_W / 2;
    localparam int LO_W    = DATA_W - HALF_W;
    localparam int MUL_A_W = LO_W + 1;
    localparam int MUL_W   = MUL_A_W + COEF_W;
    localparam int PROD_W  = DATA_W + COEF_W;
    localparam int ACC_W   = DATA_W + 4;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_W-1:0]   mul_reg;
    logic signed [MUL_W-1:0]   hi_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [PROD_W-1:0]  prod_shr;
    logic signed [ACC_W-1:0]   prod_q;
    logic                      prod_corr;
    logic [ACC_W-DATA_W:0]     acc_top;
    logic                      acc_ovf;

    // Data split into a signed upper half and an unsigned lower half, one
    // half per pass through the multiplier.
    assign mul_a = ctrl.mul_hi
                   ? MUL_A_W'(signed'(operand[DATA_W-1:LO_W]))
                   : MUL_A_W'(signed'({1'b0, operand[LO_W-1:0]}));

    // Truncation toward zero: arithmetic shift plus one for negative
    // products with discarded bits.
    assign prod_shr  = prod_reg >>> COEF_FRAC_BITS;
    assign prod_q    = prod_shr[ACC_W-1:0];
    assign prod_corr = prod_reg[PROD_W-1] && (|prod_reg[COEF_FRAC_BITS-1:0]);

    assign acc_top = acc_reg[ACC_W-1:DATA_W-1];
    assign acc_ovf = !((&acc_top) || !(|acc_top));

    always_comb
    begin
        if (acc_ovf)
        begin
            acc_sat = acc_reg[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_reg[DATA_W-1:0];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_load)
        begin
            acc_next = ACC_W'(load_val);
        end
        else if (ctrl.acc_clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_resat)
        begin
            acc_next = ACC_W'(acc_sat);
        end
        else if (ctrl.acc_add)
        begin
            acc_next = acc_reg + prod_q + ACC_W'(prod_corr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_hi || ctrl.mul_lo)
        begin
            mul_reg <= mul_a * coef;
        end
        if (ctrl.mul_lo)
        begin
            hi_reg <= mul_reg;
        end
        if (ctrl.sum)
        begin
            prod_reg <= (PROD_W'(hi_reg) <<< HALF_W) + PROD_W'(mul_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

### hw/rtl/sobc_ctrl.sv
module sobc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          out_free,
    output sobc_pkg::sobc_mac_ctrl_t      mac_ctrl,
    output sobc_pkg::sobc_dp_ctrl_t       dp_ctrl
);

    localparam int SEC_W      = sobc_pkg::SEC_W;
    localparam int COEF_IDX_W = sobc_pkg::COEF_IDX_W;

    sobc_pkg::sobc_state_t state_reg;
    sobc_pkg::sobc_state_t state_next;
    logic [SEC_W-1:0]      sec_reg;
    logic [SEC_W-1:0]      sec_next;
    logic [1:0]            term_reg;
    logic [1:0]            term_next;
    logic                  gain_reg;
    logic                  gain_next;

    always_comb
    begin
        state_next = state_reg;
        sec_next   = sec_reg;
        term_next  = term_reg;
        gain_next  = gain_reg;
        case (state_reg)
            sobc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sobc_pkg::ST_LOAD;
                    sec_next   = '0;
                end
            end
            sobc_pkg::ST_LOAD:
            begin
                state_next = sobc_pkg::ST_MUL_HI;
                term_next  = 2'd0;
                gain_next  = 1'b0;
            end
            sobc_pkg::ST_MUL_HI:
            begin
                state_next = sobc_pkg::ST_MUL_LO;
            end
            sobc_pkg::ST_MUL_LO:
            begin
                state_next = sobc_pkg::ST_SUM;
            end
            sobc_pkg::ST_SUM:
            begin
                state_next = sobc_pkg::ST_ACC;
            end
            sobc_pkg::ST_ACC:
            begin
                if (gain_reg)
                begin
                    state_next = sobc_pkg::ST_SAT_G;
                end
                else if (term_reg == 2'd1)
                begin
                    state_next = sobc_pkg::ST_SAT_W;
                end
                else if (term_reg == 2'd3)
                begin
                    state_next = sobc_pkg::ST_SAT_Y;
                end
                else
                begin
                    state_next = sobc_pkg::ST_MUL_HI;
                    term_next  = term_reg + 2'd1;
                end
            end
            sobc_pkg::ST_SAT_W:
            begin
                state_next = sobc_pkg::ST_MUL_HI;
                term_next  = 2'd2;
            end
            sobc_pkg::ST_SAT_Y:
            begin
                if (sec_reg == '0)
                begin
                    state_next = sobc_pkg::ST_GAIN_CLR;
                end
                else if (sec_reg == SEC_W'(sobc_pkg::NUM_SEC - 1))
                begin
                    state_next = sobc_pkg::ST_OUT;
                end
                else
                begin
                    state_next = sobc_pkg::ST_LOAD;
                    sec_next   = sec_reg + 1'b1;
                end
            end
            sobc_pkg::ST_GAIN_CLR:
            begin
                state_next = sobc_pkg::ST_MUL_HI;
                gain_next  = 1'b1;
            end
            sobc_pkg::ST_SAT_G:
            begin
                state_next = sobc_pkg::ST_LOAD;
                sec_next   = SEC_W'(1);
            end
            sobc_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = sobc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sobc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mac_ctrl           = '0;
        dp_ctrl            = '0;
        dp_ctrl.src_x      = gain_reg;
        dp_ctrl.delay_idx  = {sec_reg, term_reg[0]};
        dp_ctrl.coef_idx   = gain_reg ? '0
                             : COEF_IDX_W'({sec_reg, term_reg}) + COEF_IDX_W'(1);
        case (state_reg)
            sobc_pkg::ST_IDLE:     dp_ctrl.in_ready   = 1'b1;
            sobc_pkg::ST_LOAD:     mac_ctrl.acc_load  = 1'b1;
            sobc_pkg::ST_MUL_HI:   mac_ctrl.mul_hi    = 1'b1;
            sobc_pkg::ST_MUL_LO:   mac_ctrl.mul_lo    = 1'b1;
            sobc_pkg::ST_SUM:      mac_ctrl.sum       = 1'b1;
            sobc_pkg::ST_ACC:      mac_ctrl.acc_add   = 1'b1;
            sobc_pkg::ST_SAT_W:
            begin
                mac_ctrl.acc_resat = 1'b1;
                dp_ctrl.w_store    = 1'b1;
            end
            sobc_pkg::ST_SAT_Y:    dp_ctrl.y_store    = 1'b1;
            sobc_pkg::ST_GAIN_CLR: mac_ctrl.acc_clear = 1'b1;
            sobc_pkg::ST_SAT_G:    dp_ctrl.g_store    = 1'b1;
            sobc_pkg::ST_OUT:      dp_ctrl.out_load   = out_free;
            default:               dp_ctrl.in_ready   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sobc_pkg::ST_IDLE;
            sec_reg   <= '0;
            term_reg  <= '0;
            gain_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            term_reg  <= term_next;
            gain_reg  <= gain_next;
        end
    end

endmodule
